>>> hdl/pfre_pkg.sv
// Shared constants, codes and handshake types of the page frame replacement engine.
package pfre_pkg;

    localparam int MAX_FRAMES   = 64;
    localparam int FRAME_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W        = $clog2(MAX_FRAMES + 1);
    localparam int AGE_W        = 32;
    localparam logic [AGE_W-1:0] AGE_TOP = {1'b1, {(AGE_W-1){1'b0}}};
    localparam int NRU_PERIOD   = 10;
    localparam int NRU_CNT_W    = 4;
    localparam int RAND_W       = 32;
    localparam int POLICY_W     = 3;

    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 8;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 7;

    // policy codes
    localparam logic [POLICY_W-1:0] POL_FIFO   = 3'd0;
    localparam logic [POLICY_W-1:0] POL_CLOCK  = 3'd1;
    localparam logic [POLICY_W-1:0] POL_RANDOM = 3'd2;
    localparam logic [POLICY_W-1:0] POL_AGING  = 3'd3;
    localparam logic [POLICY_W-1:0] POL_NRU    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'd1;

    // item opcodes
    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_MISS   = 1'b1;

    typedef struct packed {
        logic              start;
        logic [RAND_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] rem;
    } div_rsp_t;

endpackage

>>> hdl/pfre_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/pfre_div.sv
// Bit-serial remainder unit: dividend mod divisor, one quotient bit per cycle.
module pfre_div (
    input  logic               clk,
    input  logic               rst_n,
    input  pfre_pkg::div_req_t req,
    output pfre_pkg::div_rsp_t rsp
);
    import pfre_pkg::*;

    localparam int STEP_W = $clog2(RAND_W + 1);

    logic [STEP_W-1:0] step_reg, step_next;
    logic [RAND_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dsr_reg, dsr_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;

    always_comb
    begin
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[RAND_W-1]};
        if (req.start)
        begin
            step_next = STEP_W'(RAND_W);
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (step_reg != '0)
        begin
            quo_next  = {quo_reg[RAND_W-2:0], 1'b0};
            // remainder stays below the divisor, so the trial fits CNT_W+1 bits
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = CNT_W'(trial - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = trial[CNT_W-1:0];
            end
            step_next = step_reg - STEP_W'(1);
            done_next = (step_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> hdl/page_frame_replacement_engine.sv
// Page frame replacement engine: frame bookkeeping and victim selection sequencer.
//
// Input channel s_*: one transfer per item. s_tuser is the opcode (0 access to a
// resident frame, 1 page miss). Output channel m_*: exactly one result per item.
// Configuration: cfg_we/cfg_index/cfg_wdata, index 0 policy, index 1 frame count;
// write only while the block is idle.
// Sequence per item (nf = managed frames): an access goes straight to the result;
// a miss from the free pool and a fifo miss go through the final step; clock
// scans from the hand; random uses the 32-step remainder unit; aging makes one
// age RAM read and write-back per frame; nru makes a class count pass, a
// remainder and a select pass. One item is in work at a time; s_tready is low
// until its result is in the output register.
// The output register holds one finished result, so the next item is taken
// while it waits for m_tready; a stalled receiver then stops the block at the
// end of that next item. Reset clears all bits, ages, hand and counters at once
// (per-frame valid bits stand in for the age RAM contents), no clearing pass.
module page_frame_replacement_engine (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // [5:0] frame_index, [6] is_write, [7] wr_protect, [39:8] rand_value
    input  logic [pfre_pkg::IN_TDATA_W-1:0]       s_tdata,
    // [0] opcode
    input  logic                                  s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [5:0] chosen_frame, [6] from_free_pool, [7] victim_dirty
    output logic [pfre_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                  cfg_we,
    input  logic [pfre_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pfre_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import pfre_pkg::*;

    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [ST_W-1:0] ST_CLK_SCAN = 4'd1;
    localparam logic [ST_W-1:0] ST_AG_RD    = 4'd2;
    localparam logic [ST_W-1:0] ST_AG_WR    = 4'd3;
    localparam logic [ST_W-1:0] ST_NRU_CNT  = 4'd4;
    localparam logic [ST_W-1:0] ST_NRU_DIV  = 4'd5;
    localparam logic [ST_W-1:0] ST_DIV_WAIT = 4'd6;
    localparam logic [ST_W-1:0] ST_NRU_SEL  = 4'd7;
    localparam logic [ST_W-1:0] ST_FINAL    = 4'd8;
    localparam logic [ST_W-1:0] ST_RESP     = 4'd9;

    logic [ST_W-1:0]       state_reg, state_next;
    logic [POLICY_W-1:0]   policy_reg, policy_next;
    logic [CNT_W-1:0]      frames_reg, frames_next;
    logic [POLICY_W-1:0]   pol_reg, pol_next;
    logic [MAX_FRAMES-1:0] ref_reg, ref_next;
    logic [MAX_FRAMES-1:0] mod_reg, mod_next;
    logic [MAX_FRAMES-1:0] agev_reg, agev_next;
    logic [FRAME_W-1:0]    hand_reg, hand_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [NRU_CNT_W-1:0]  nru_reg, nru_next;
    logic                  wipe_reg, wipe_next;
    logic [FRAME_W-1:0]    idx_reg, idx_next;
    logic [FRAME_W-1:0]    victim_reg, victim_next;
    logic                  fresh_reg, fresh_next;
    logic                  wr_reg, wr_next;
    logic                  prot_reg, prot_next;
    logic [RAND_W-1:0]     rand_reg, rand_next;
    logic [AGE_W-1:0]      best_reg, best_next;
    logic [CNT_W-1:0]      cls_cnt_reg [4];
    logic [CNT_W-1:0]      cls_cnt_next [4];
    logic [1:0]            cls_reg, cls_next;
    logic [CNT_W-1:0]      seen_reg, seen_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [OUT_TDATA_W-1:0] res_reg, res_next;
    logic                  oval_reg, oval_next;
    logic [OUT_TDATA_W-1:0] odata_reg, odata_next;

    logic [CNT_W-1:0]      nf;
    logic                  idx_last;
    logic [FRAME_W-1:0]    hand_n;
    logic [FRAME_W-1:0]    hand_inc;
    logic [FRAME_W-1:0]    in_frame;
    logic                  in_wr, in_prot;
    logic [RAND_W-1:0]     in_rand;
    logic [AGE_W-1:0]      age_q;
    logic [AGE_W-1:0]      age_rd, age_new;
    logic                  age_we;
    logic [1:0]            idx_cls;
    logic [NRU_CNT_W-1:0]  nru_inc;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    assign in_frame = s_tdata[FRAME_W-1:0];
    assign in_wr    = s_tdata[6];
    assign in_prot  = s_tdata[7];
    assign in_rand  = s_tdata[39:8];

    assign nf = (frames_reg == '0) ? CNT_W'(1) :
                (frames_reg > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : frames_reg;
    assign idx_last = ({1'b0, idx_reg} + CNT_W'(1)) == nf;
    assign hand_n   = ({1'b0, hand_reg} >= nf) ? '0 : hand_reg;
    assign idx_cls  = {ref_reg[idx_reg], mod_reg[idx_reg]};
    assign nru_inc  = nru_reg + NRU_CNT_W'(1);

    always_comb
    begin
        // advance from the current hand (normalized on entry to the scan)
        if (({1'b0, hand_reg} + CNT_W'(1)) == nf)
        begin
            hand_inc = '0;
        end
        else
        begin
            hand_inc = hand_reg + FRAME_W'(1);
        end
    end

    assign age_rd  = agev_reg[idx_reg] ? age_q : '0;
    assign age_new = (age_rd >> 1) | (ref_reg[idx_reg] ? AGE_TOP : '0);
    assign age_we  = (state_reg == ST_AG_WR);

    pfre_ram #(
        .WIDTH(AGE_W),
        .DEPTH(MAX_FRAMES)
    ) u_age_ram (
        .clk  (clk),
        .we   (age_we),
        .waddr(idx_reg),
        .wdata(age_new),
        .raddr(idx_reg),
        .rdata(age_q)
    );

    pfre_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    always_comb
    begin
        state_next  = state_reg;
        policy_next = policy_reg;
        frames_next = frames_reg;
        pol_next    = pol_reg;
        ref_next    = ref_reg;
        mod_next    = mod_reg;
        agev_next   = agev_reg;
        hand_next   = hand_reg;
        fill_next   = fill_reg;
        nru_next    = nru_reg;
        wipe_next   = wipe_reg;
        idx_next    = idx_reg;
        victim_next = victim_reg;
        fresh_next  = fresh_reg;
        wr_next     = wr_reg;
        prot_next   = prot_reg;
        rand_next   = rand_reg;
        best_next   = best_reg;
        cls_cnt_next = cls_cnt_reg;
        cls_next    = cls_reg;
        seen_next   = seen_reg;
        k_next      = k_reg;
        res_next    = res_reg;
        oval_next   = oval_reg && !m_tready;
        odata_next  = odata_reg;
        div_req.start    = 1'b0;
        div_req.dividend = rand_reg;
        div_req.divisor  = nf;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_POLICY: policy_next = cfg_wdata[POLICY_W-1:0];
                CFG_FRAMES: frames_next = cfg_wdata;
                default:    ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    wr_next   = in_wr;
                    prot_next = in_prot;
                    rand_next = in_rand;
                    wipe_next = 1'b0;
                    fresh_next = 1'b0;
                    idx_next  = '0;
                    pol_next  = (policy_reg > POL_NRU) ? POL_FIFO : policy_reg;
                    if (s_tuser == OP_ACCESS)
                    begin
                        ref_next[in_frame] = 1'b1;
                        if (in_wr && !in_prot)
                        begin
                            mod_next[in_frame] = 1'b1;
                        end
                        res_next   = {2'b00, in_frame};
                        state_next = ST_RESP;
                    end
                    else if (fill_reg < nf)
                    begin
                        victim_next = fill_reg[FRAME_W-1:0];
                        fill_next   = fill_reg + CNT_W'(1);
                        fresh_next  = 1'b1;
                        state_next  = ST_FINAL;
                    end
                    else
                    begin
                        hand_next = hand_n;
                        case ((policy_reg > POL_NRU) ? POL_FIFO : policy_reg)
                            POL_CLOCK:
                            begin
                                state_next = ST_CLK_SCAN;
                            end
                            POL_RANDOM:
                            begin
                                div_req.start    = 1'b1;
                                div_req.dividend = in_rand;
                                state_next = ST_DIV_WAIT;
                            end
                            POL_AGING:
                            begin
                                state_next = ST_AG_RD;
                            end
                            POL_NRU:
                            begin
                                if (nru_inc >= NRU_CNT_W'(NRU_PERIOD))
                                begin
                                    nru_next  = '0;
                                    wipe_next = 1'b1;
                                end
                                else
                                begin
                                    nru_next = nru_inc;
                                end
                                for (int c = 0; c < 4; c++)
                                begin
                                    cls_cnt_next[c] = '0;
                                end
                                state_next = ST_NRU_CNT;
                            end
                            default:
                            begin
                                victim_next = hand_n;
                                hand_next   = (({1'b0, hand_n} + CNT_W'(1)) == nf) ?
                                              '0 : hand_n + FRAME_W'(1);
                                state_next  = ST_FINAL;
                            end
                        endcase
                    end
                end
            end

            ST_CLK_SCAN:
            begin
                hand_next = hand_inc;
                if (!ref_reg[hand_reg])
                begin
                    victim_next = hand_reg;
                    state_next  = ST_FINAL;
                end
                else
                begin
                    ref_next[hand_reg] = 1'b0;
                end
            end

            ST_AG_RD:
            begin
                state_next = ST_AG_WR;
            end

            ST_AG_WR:
            begin
                agev_next[idx_reg] = 1'b1;
                ref_next[idx_reg]  = 1'b0;
                // strict compare keeps ties on the lower index
                if (idx_reg == '0 || age_new < best_reg)
                begin
                    best_next   = age_new;
                    victim_next = idx_reg;
                end
                if (idx_last)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    idx_next   = idx_reg + FRAME_W'(1);
                    state_next = ST_AG_RD;
                end
            end

            ST_NRU_CNT:
            begin
                cls_cnt_next[idx_cls] = cls_cnt_reg[idx_cls] + CNT_W'(1);
                if (idx_last)
                begin
                    state_next = ST_NRU_DIV;
                end
                else
                begin
                    idx_next = idx_reg + FRAME_W'(1);
                end
            end

            ST_NRU_DIV:
            begin
                if (cls_cnt_reg[0] != '0)
                begin
                    cls_next = 2'd0;
                end
                else if (cls_cnt_reg[1] != '0)
                begin
                    cls_next = 2'd1;
                end
                else if (cls_cnt_reg[2] != '0)
                begin
                    cls_next = 2'd2;
                end
                else
                begin
                    cls_next = 2'd3;
                end
                div_req.start   = 1'b1;
                div_req.divisor = cls_cnt_reg[cls_next];
                state_next = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (pol_reg == POL_RANDOM)
                    begin
                        victim_next = div_rsp.rem[FRAME_W-1:0];
                        state_next  = ST_FINAL;
                    end
                    else
                    begin
                        k_next     = div_rsp.rem;
                        seen_next  = '0;
                        idx_next   = '0;
                        state_next = ST_NRU_SEL;
                    end
                end
            end

            ST_NRU_SEL:
            begin
                idx_next = idx_reg + FRAME_W'(1);
                if (idx_cls == cls_reg && seen_reg == k_reg)
                begin
                    victim_next = idx_reg;
                    state_next  = ST_FINAL;
                end
                else
                begin
                    if (idx_cls == cls_reg)
                    begin
                        seen_next = seen_reg + CNT_W'(1);
                    end
                    if (idx_last)
                    begin
                        victim_next = '0;
                        state_next  = ST_FINAL;
                    end
                end
            end

            ST_FINAL:
            begin
                if (wipe_reg)
                begin
                    for (int i = 0; i < MAX_FRAMES; i++)
                    begin
                        if (CNT_W'(i) < nf)
                        begin
                            ref_next[i] = 1'b0;
                        end
                    end
                end
                res_next = {(!fresh_reg && mod_reg[victim_reg]), fresh_reg, victim_reg};
                ref_next[victim_reg]  = 1'b1;
                mod_next[victim_reg]  = wr_reg && !prot_reg;
                agev_next[victim_reg] = 1'b0;
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (!oval_reg || m_tready)
                begin
                    oval_next  = 1'b1;
                    odata_next = res_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            policy_reg <= POL_FIFO;
            frames_reg <= CNT_W'(32);
            ref_reg    <= '0;
            mod_reg    <= '0;
            agev_reg   <= '0;
            hand_reg   <= '0;
            fill_reg   <= '0;
            nru_reg    <= '0;
            wipe_reg   <= 1'b0;
            oval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            policy_reg <= policy_next;
            frames_reg <= frames_next;
            ref_reg    <= ref_next;
            mod_reg    <= mod_next;
            agev_reg   <= agev_next;
            hand_reg   <= hand_next;
            fill_reg   <= fill_next;
            nru_reg    <= nru_next;
            wipe_reg   <= wipe_next;
            oval_reg   <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pol_reg     <= pol_next;
        idx_reg     <= idx_next;
        victim_reg  <= victim_next;
        fresh_reg   <= fresh_next;
        wr_reg      <= wr_next;
        prot_reg    <= prot_next;
        rand_reg    <= rand_next;
        best_reg    <= best_next;
        cls_cnt_reg <= cls_cnt_next;
        cls_reg     <= cls_next;
        seen_reg    <= seen_next;
        k_reg       <= k_next;
        res_reg     <= res_next;
        odata_reg   <= odata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = oval_reg;
    assign m_tdata  = odata_reg;

endmodule

>>> hdl/pfre_checker.sv
// Port-level checker for the page frame replacement engine, bound to the top level.
module pfre_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pfre_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import pfre_pkg::*;

    // a result stalled by the receiver stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("stalled result dropped");

    // and stays unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("stalled result changed");

    // a frame from the free pool never needs a write back
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[6] && m_tdata[7]))
        else $error("free frame reported dirty");

    // one item in work at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

endmodule

bind page_frame_replacement_engine pfre_checker u_pfre_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

>>> dv/testbench.sv
// Self-checking testbench for the page frame replacement engine.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pfre_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int PHASE_ITEMS = 70;

    typedef struct packed {
        logic             op;
        logic [5:0]       fi;
        logic             wr;
        logic             prot;
        logic [31:0]      rnd;
    } page_req_t;

    typedef struct packed {
        logic             dirty;
        logic             fresh;
        logic [5:0]       frame;
    } grant_t;

    typedef struct packed {
        page_req_t        req;
        logic             typed;
        grant_t           want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    page_frame_replacement_engine uut (.*);

    always #5 clk = ~clk;

    // shadow copy of the frame bookkeeping
    bit        ref_bit [MAX_FRAMES];
    bit        mod_bit [MAX_FRAMES];
    bit [31:0] age [MAX_FRAMES];
    int unsigned hand, fill_count, nru_calls;
    bit [2:0]  policy = POL_FIFO;
    bit [6:0]  frame_cfg = 7'd32;

    grant_t grant_q[$];
    int mismatches, items_sent, results_seen, misses_sent, evictions;

    function automatic grant_t predict_grant(page_req_t r);
        grant_t g;
        int unsigned nf, f, best, c, k, seen, i;
        int unsigned cnt[4];
        bit wipe;
        nf = (frame_cfg < 1) ? 1 : (frame_cfg > MAX_FRAMES) ? MAX_FRAMES : frame_cfg;
        g = '0;
        if (r.op == OP_ACCESS)
        begin
            ref_bit[r.fi] = 1'b1;
            if (r.wr && !r.prot) mod_bit[r.fi] = 1'b1;
            g.frame = r.fi;
            return g;
        end
        if (fill_count < nf)
        begin
            f = fill_count;
            fill_count++;
            g.fresh = 1'b1;
        end
        else
        begin
            if (hand >= nf) hand = 0;
            case (policy)
                POL_CLOCK:
                begin
                    forever
                    begin
                        f = hand;
                        hand = (hand + 1) % nf;
                        if (!ref_bit[f]) break;
                        ref_bit[f] = 1'b0;
                    end
                end
                POL_RANDOM: f = r.rnd % nf;
                POL_AGING:
                begin
                    best = 0;
                    for (i = 0; i < nf; i++)
                    begin
                        age[i] = age[i] >> 1;
                        if (ref_bit[i])
                        begin
                            age[i] |= AGE_TOP;
                            ref_bit[i] = 1'b0;
                        end
                        if (age[i] < age[best]) best = i;
                    end
                    f = best;
                end
                POL_NRU:
                begin
                    nru_calls = (nru_calls + 1) & 4'hF;
                    wipe = nru_calls >= NRU_PERIOD;
                    if (wipe) nru_calls = 0;
                    cnt = '{0, 0, 0, 0};
                    for (i = 0; i < nf; i++) cnt[2 * ref_bit[i] + mod_bit[i]]++;
                    c = 0;
                    while (c < 3 && cnt[c] == 0) c++;
                    k = r.rnd % cnt[c];
                    seen = 0;
                    for (i = 0; i < nf; i++)
                        if (2 * ref_bit[i] + mod_bit[i] == c)
                        begin
                            if (seen == k) break;
                            seen++;
                        end
                    f = (i >= nf) ? 0 : i;
                    if (wipe)
                        for (i = 0; i < nf; i++) ref_bit[i] = 1'b0;
                end
                default:
                begin
                    f = hand;
                    hand = (hand + 1) % nf;
                end
            endcase
            g.dirty = mod_bit[f];
            evictions++;
        end
        ref_bit[f] = 1'b0;
        mod_bit[f] = 1'b0;
        age[f] = '0;
        ref_bit[f] = 1'b1;
        if (r.wr && !r.prot) mod_bit[f] = 1'b1;
        g.frame = f[5:0];
        return g;
    endfunction

    // one transfer on the input side; caller is at a rising edge
    task automatic send_req(page_req_t r, logic typed, grant_t want);
        grant_t g;
        s_tdata <= {r.rnd, r.prot, r.wr, r.fi};
        s_tuser <= r.op;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        g = predict_grant(r);
        grant_q.insert(grant_q.size(), typed ? want : g);
        items_sent++;
        if (r.op == OP_MISS) misses_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (grant_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_POLICY) policy = val[2:0];
        else frame_cfg = val;
        @(posedge clk);
    endtask

    function automatic page_req_t random_req();
        page_req_t r;
        r.op = ($urandom_range(0, 9) < 6) ? OP_MISS : OP_ACCESS;
        r.fi = 6'($urandom_range(0, 63));
        r.wr = ($urandom_range(0, 1) == 1);
        r.prot = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 7))
            0: r.rnd = '0;
            1: r.rnd = '1;
            default: r.rnd = $urandom;
        endcase
        return r;
    endfunction

    // input side gaps: bursts of random length
    int burst_left = 0;
    task automatic maybe_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 1) ? $urandom_range(1, 6) : $urandom_range(10, 40);
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    // output side stall pattern
    int stall_mode = 0, stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 200);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= (stall_left % 7) < 2;
        endcase
    end

    // result checker
    always @(posedge clk)
    begin
        grant_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            results_seen++;
            if (grant_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", got);
            end
            else
            begin
                want = grant_q.pop_front();
                if (got.frame !== want.frame || got.fresh !== want.fresh ||
                    got.dirty !== want.dirty)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: frame %0d/%0d fresh %b/%b dirty %b/%b (exp/act)",
                                 results_seen, want.frame, got.frame, want.fresh,
                                 got.fresh, want.dirty, got.dirty);
                end
            end
        end
    end

    // watchdog on transfers
    int quiet = 0;
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    stim_row_t rows[$];
    int phase_pol[] = '{1, 2, 3, 4, 0, 1, 3, 4, 4, 5, 6, 7, 2, 3, 4, 1, 2};
    int phase_frm[] = '{4, 64, 8, 16, 1, 64, 64, 64, 2, 3, 0, 127, 1, 1, 1, 2, 5};

    function automatic void add_row(page_req_t req, logic typed, grant_t want);
        stim_row_t row;
        row.req = req;
        row.typed = typed;
        row.want = want;
        rows.insert(rows.size(), row);
    endfunction

    initial
    begin
        page_req_t r;
        // directed: fresh frames at reset settings, extremes of every field
        add_row('{OP_MISS, 6'd63, 1'b1, 1'b0, 32'hFFFFFFFF}, 1'b1, '{1'b0, 1'b1, 6'd0});
        add_row('{OP_ACCESS, 6'd63, 1'b1, 1'b0, 32'h0}, 1'b1, '{1'b0, 1'b0, 6'd63});
        add_row('{OP_ACCESS, 6'd40, 1'b1, 1'b1, 32'hFFFFFFFF}, 1'b1, '{1'b0, 1'b0, 6'd40});
        add_row('{OP_ACCESS, 6'd0, 1'b0, 1'b0, 32'h0}, 1'b1, '{1'b0, 1'b0, 6'd0});
        add_row('{OP_MISS, 6'd0, 1'b0, 1'b1, 32'h0}, 1'b1, '{1'b0, 1'b1, 6'd1});
        add_row('{OP_MISS, 6'd21, 1'b1, 1'b1, 32'hAAAAAAAA}, 1'b1, '{1'b0, 1'b1, 6'd2});
        add_row('{OP_MISS, 6'd42, 1'b1, 1'b0, 32'h55555555}, 1'b1, '{1'b0, 1'b1, 6'd3});
        add_row('{OP_ACCESS, 6'd3, 1'b1, 1'b0, 32'h0}, 1'b0, '0);
        add_row('{OP_ACCESS, 6'd33, 1'b0, 1'b0, 32'h0}, 1'b0, '0);
        add_row('{OP_ACCESS, 6'd31, 1'b1, 1'b0, 32'h0}, 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].want);
        wait_idle();

        // a policy and frame count (0 to 127) per phase so every policy evicts, each with its own mix
        for (int p = 0; p < phase_pol.size() + 1; p++)
        begin
            if (p < phase_pol.size())
            begin
                write_reg(CFG_POLICY, CFG_DATA_W'(phase_pol[p]));
                write_reg(CFG_FRAMES, CFG_DATA_W'(phase_frm[p]));
            end
            else
            begin
                write_reg(CFG_POLICY, CFG_DATA_W'($urandom_range(0, 4)));
                write_reg(CFG_FRAMES, CFG_DATA_W'($urandom_range(1, 64)));
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = random_req();
                send_req(r, 1'b0, '0);
                if (p == 3 && n == PHASE_ITEMS / 2)
                    wait_idle();
                else
                    maybe_gap();
            end
            wait_idle();
        end

        repeat (50) @(posedge clk);
        $display("%0d items (%0d misses, %0d evictions), %0d results checked",
                 items_sent, misses_sent, evictions, results_seen);
        $display("policies fifo/clock/random/aging/nru/unknown, frame counts 0..127");
        if (mismatches == 0 && grant_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

>>> sim.f
hdl/pfre_pkg.sv
hdl/pfre_ram.sv
hdl/pfre_div.sv
hdl/page_frame_replacement_engine.sv
hdl/pfre_checker.sv
dv/testbench.sv
